// File: rtl/hptc_pkg.sv
// shared types, register codes and saturation helper for the hand position controller
// no dependencies
package hptc_pkg;

    typedef enum logic [1:0] {
        CFG_GAIN_H   = 2'd0,
        CFG_GAIN_V   = 2'd1,
        CFG_MIN_HAND = 2'd2,
        CFG_HEADWAY  = 2'd3
    } cfg_idx_t;

    localparam logic [16:0] KG_ONE = 17'd65536;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // request fields that ride along the pipeline
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] refp;
        logic [2:0][31:0] vel;
        logic [2:0][15:0] dir;
    } side_t;

    function automatic logic [31:0] sat32(input logic signed [38:0] v);
        logic [31:0] r;
        if (v > 39'sh00_7FFF_FFFF)
            r = S32_MAX;
        else if (v < -39'sh00_8000_0000)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/hptc_sqrt.sv
// pipelined integer square root, four result bits per stage, eight stages
// depends on hptc_pkg for the sideband type
module hptc_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   radicand,
    input  hptc_pkg::side_t in_side,
    output logic          out_valid,
    output logic [31:0]   root,
    output hptc_pkg::side_t out_side
);
    import hptc_pkg::*;

    localparam int STAGES = 8;
    localparam int STEPS  = 4;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [63:0] rem_in;
        logic [63:0] r_in;
        side_t       side_cur;
        logic        v_in;
        logic [63:0] rem_next;
        logic [63:0] r_next;
        logic [63:0] rem_reg;
        logic [63:0] r_reg;
        side_t       side_reg;
        logic        v_reg;

        if (s == 0) begin : g_first
            assign rem_in   = radicand;
            assign r_in     = 64'd0;
            assign side_cur = in_side;
            assign v_in     = in_valid;
        end
        else begin : g_rest
            assign rem_in   = g_stage[s-1].rem_reg;
            assign r_in     = g_stage[s-1].r_reg;
            assign side_cur = g_stage[s-1].side_reg;
            assign v_in     = g_stage[s-1].v_reg;
        end

        always_comb
        begin
            logic [63:0] bitv;
            rem_next = rem_in;
            r_next   = r_in;
            for (int j = 0; j < STEPS; j++)
            begin
                bitv = 64'd1 << (62 - 2 * (s * STEPS + j));
                if (rem_next >= r_next + bitv)
                begin
                    rem_next = rem_next - (r_next + bitv);
                    r_next   = (r_next >> 1) + bitv;
                end
                else
                begin
                    r_next = r_next >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                r_reg    <= r_next;
                side_reg <= side_cur;
            end
        end
    end

    assign out_valid = g_stage[STAGES-1].v_reg;
    assign root      = g_stage[STAGES-1].r_reg[31:0];
    assign out_side  = g_stage[STAGES-1].side_reg;

endmodule

// File: rtl/hand_position_trajectory_control_core.sv
// hand position trajectory tracking controller, top level
// depends on hptc_pkg and hptc_sqrt
//
// usage:
//   input channel in_valid / in_stall carries vehicle position, reference
//   position and velocity and the forward unit vector; output channel
//   out_valid / out_stall returns the three velocity commands.
//   a request is taken on a rising edge with valid high and stall low.
//   gains and hand length settings are written through cfg_wen / cfg_index /
//   cfg_data while no request is in flight.
// pipeline: four front stages, eight square root stages and four back stages
//   lie between input request and output valid.
// throughput: one request per cycle while the pipeline is not stalled; the
//   eight-stage square root pipeline and the multiplier stages set the depth, none of them iterates.
// reset: pipeline valid bits clear, configuration registers return to their defaults.
// stall: when the output register holds a result and out_stall is high the
//   whole pipeline freezes and in_stall rises; nothing is dropped or repeated.
module hand_position_trajectory_control_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  hptc_pkg::cfg_idx_t cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_depth,
    input  logic signed [31:0] ref_x,
    input  logic signed [31:0] ref_y,
    input  logic signed [31:0] ref_z,
    input  logic signed [31:0] ref_vel_x,
    input  logic signed [31:0] ref_vel_y,
    input  logic signed [31:0] ref_vel_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] cmd_x,
    output logic signed [31:0] cmd_y,
    output logic signed [31:0] cmd_z
);
    import hptc_pkg::*;

    localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    logic [15:0] gain_h_reg, gain_v_reg;
    logic [23:0] min_hand_reg;
    logic [16:0] headway_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_h_reg   <= 16'd410;
            gain_v_reg   <= 16'd1024;
            min_hand_reg <= 24'd65536;
            headway_reg  <= 17'd32768;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_GAIN_H:   gain_h_reg   <= cfg_data[15:0];
                CFG_GAIN_V:   gain_v_reg   <= cfg_data[15:0];
                CFG_MIN_HAND: min_hand_reg <= cfg_data;
                CFG_HEADWAY:  headway_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v12, v13_reg, v14_reg, v15_reg, v16_reg;

    assign adv      = !v16_reg || !out_stall;
    assign in_stall = !adv;

    side_t side_in, side1_reg, side2_reg, side3_reg, side4_reg, side12;
    side_t side13_reg, side14_reg, side15_reg;

    assign side_in.pos  = {pos_depth, pos_y, pos_x};
    assign side_in.refp = {ref_z, ref_y, ref_x};
    assign side_in.vel  = {ref_vel_z, ref_vel_y, ref_vel_x};
    assign side_in.dir  = {dir_z, dir_y, dir_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v13_reg <= v12;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            v16_reg <= v15_reg;
        end
    end

    // stage 1: saturated error magnitudes, scaled minimum hand length
    logic [2:0][31:0] errmag_next, errmag1_reg;
    logic [31:0]      e0_next, e0_1_reg;

    always_comb
    begin
        logic signed [32:0] d;
        logic [31:0]        err;
        for (int i = 0; i < 3; i++)
        begin
            d   = $signed({side_in.pos[i][31], side_in.pos[i]})
                - $signed({side_in.refp[i][31], side_in.refp[i]});
            err = sat32(39'(d));
            errmag_next[i] = err[31] ? 32'(32'd0 - err) : err;
        end
        e0_next = (32'(min_hand_reg) << LSH) >> RSH;
    end

    // stage 2: headway scaling and e0 squared
    logic [16:0]      kg;
    logic [2:0][31:0] s2_reg;
    logic [63:0]      e0sq2_reg, e0sq3_reg;
    logic [2:0][63:0] sq3_reg;
    logic [63:0]      rad4_reg;

    assign kg = (headway_reg > KG_ONE) ? KG_ONE : headway_reg;

    always_ff @(posedge clk)
    begin
        logic [48:0] p;
        logic [65:0] sum;
        if (adv)
        begin
            errmag1_reg <= errmag_next;
            e0_1_reg    <= e0_next;
            side1_reg   <= side_in;
            for (int i = 0; i < 3; i++)
            begin
                p = 49'(errmag1_reg[i]) * 49'(kg);
                s2_reg[i] <= p[47:16];
                sq3_reg[i] <= 64'(s2_reg[i]) * 64'(s2_reg[i]);
            end
            e0sq2_reg <= 64'(e0_1_reg) * 64'(e0_1_reg);
            side2_reg <= side1_reg;
            e0sq3_reg <= e0sq2_reg;
            side3_reg <= side2_reg;
            // stage 4: saturating sum of squares
            sum = 66'(e0sq3_reg) + 66'(sq3_reg[0]) + 66'(sq3_reg[1]) + 66'(sq3_reg[2]);
            rad4_reg  <= (sum[65:64] != 2'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
            side4_reg <= side3_reg;
        end
    end

    logic [31:0] root12;

    hptc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .radicand  (rad4_reg),
        .in_side   (side4_reg),
        .out_valid (v12),
        .root      (root12),
        .out_side  (side12)
    );

    // stages 13 to 16: hand offset, hand point and error, gain, command
    logic [2:0][48:0] prod13_reg;
    logic [2:0]       neg13_reg, neg14_reg, neg15_reg;
    logic [2:0][32:0] dmag14_reg;
    logic [2:0][36:0] p15_reg;
    logic [2:0][31:0] cmd_reg;

    always_ff @(posedge clk)
    begin
        logic [16:0]        dmag;
        logic [34:0]        off;
        logic signed [36:0] soff;
        logic signed [36:0] h;
        logic [31:0]        hand;
        logic signed [32:0] diff;
        logic [15:0]        g;
        logic [48:0]        gp;
        logic signed [38:0] c;
        if (adv)
        begin
            side13_reg <= side12;
            side14_reg <= side13_reg;
            side15_reg <= side14_reg;
            for (int i = 0; i < 3; i++)
            begin
                dmag = side12.dir[i][15] ? 17'(17'd0 - {1'b1, side12.dir[i]})
                                         : {1'b0, side12.dir[i]};
                prod13_reg[i] <= 49'(dmag) * 49'(root12);
                neg13_reg[i]  <= side12.dir[i][15];

                off  = prod13_reg[i][48:14];
                soff = neg13_reg[i] ? -$signed({2'b00, off}) : $signed({2'b00, off});
                h    = 37'($signed(side13_reg.pos[i])) + soff;
                hand = sat32(39'(h));
                diff = $signed({side13_reg.refp[i][31], side13_reg.refp[i]})
                     - $signed({hand[31], hand});
                dmag14_reg[i] <= diff[32] ? 33'(33'd0 - diff) : 33'(diff);
                neg14_reg[i]  <= diff[32];

                g  = (i < 2) ? gain_h_reg : gain_v_reg;
                gp = 49'(g) * 49'(dmag14_reg[i]);
                p15_reg[i]   <= gp[48:12];
                neg15_reg[i] <= neg14_reg[i];

                c = neg15_reg[i] ? -$signed({2'b00, p15_reg[i]}) : $signed({2'b00, p15_reg[i]});
                c = c + 39'($signed(side15_reg.vel[i]));
                cmd_reg[i] <= sat32(c);
            end
        end
    end

    assign out_valid = v16_reg;
    assign cmd_x     = cmd_reg[0];
    assign cmd_y     = cmd_reg[1];
    assign cmd_z     = cmd_reg[2];

    a_stall_map: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({v1_reg, v4_reg, v13_reg, v16_reg}))
        else $error("pipeline valid bits moved during stall");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !in_valid) |=> !v1_reg)
        else $error("stage one valid without an accepted request");

    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v15_reg) |=> out_valid)
        else $error("result lost at output register");

endmodule
